### rtl/fcch_pkg.sv
// ----------------------------------------------------------------------------
// fcch_pkg: shared types, constants and functions
// Character classes, hex encode and decode, checksum fold and CSR layout for
// the filtered character checksum block.
// ----------------------------------------------------------------------------
package fcch_pkg;

   // Field widths
   localparam int CHAR_W = 8;
   localparam int SUM_W  = 16;
   localparam int CNT_W  = 2;

   // CSR layout: one 32-bit register per word, paddr covers one word past it
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_VERIFY_MODE = 1'd0;

   // Character and checksum constants
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_LO  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_HI  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] HEX_LETTER_OFS = 8'd55;
   localparam logic [CHAR_W-1:0] HEX_DIGIT_OFS  = 8'd48;
   localparam logic [CHAR_W-1:0] CHECK_GOOD     = 8'hFF;
   localparam logic [CNT_W-1:0]  CNT_FULL       = 2'd2;

   // Configuration handed from the register block to the datapath
   typedef struct packed {
      logic verify_mode;
   } cfg_type;

   // True for digits, capital letters and space
   function automatic logic char_counts(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_DIGIT_LO) && (c <= CHAR_DIGIT_HI)) ||
             ((c >= CHAR_UPPER_LO) && (c <= CHAR_UPPER_HI)) ||
             (c == CHAR_SPACE);
   endfunction

   // Nibble to upper-case ASCII hex
   function automatic logic [CHAR_W-1:0] nibble_to_ascii(input logic [3:0] n);
      logic [CHAR_W-1:0] w;
      w = {4'b0, n};
      return (n > 4'd9) ? w + HEX_LETTER_OFS : w + HEX_DIGIT_OFS;
   endfunction

   // ASCII hex to value, no range check, wraps in 8 bits
   function automatic logic [CHAR_W-1:0] ascii_to_value(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_UPPER_LO) && (c <= CHAR_UPPER_HI)) ? c - HEX_LETTER_OFS
                                                            : c - HEX_DIGIT_OFS;
   endfunction

   // Fold the high byte into the low byte once, keep 8 bits
   function automatic logic [CHAR_W-1:0] fold_sum(input logic [SUM_W-1:0] s);
      return s[7:0] + s[15:8];
   endfunction

endpackage

### rtl/fcch_req_if.sv
// ----------------------------------------------------------------------------
// fcch_req_if: character channel
// Valid/ready channel carrying one message character per transaction.
// ----------------------------------------------------------------------------
interface fcch_req_if
   import fcch_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink   (input valid, input char_in, input last_char, output ready);

endinterface

### rtl/fcch_rsp_if.sv
// ----------------------------------------------------------------------------
// fcch_rsp_if: result channel
// Valid/ready channel carrying one checksum result per transaction.
// ----------------------------------------------------------------------------
interface fcch_rsp_if
   import fcch_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] hex_high;
   logic [CHAR_W-1:0] hex_low;
   logic              check_ok;

   modport source (output valid, output hex_high, output hex_low, output check_ok,
                   input ready);
   modport sink   (input valid, input hex_high, input hex_low, input check_ok,
                   output ready);

endinterface

### rtl/fcch_csr.sv
// ----------------------------------------------------------------------------
// fcch_csr: configuration registers
// APB-style register block holding the mode select.
// ----------------------------------------------------------------------------
module fcch_csr
   import fcch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic                  verify_mode_ff;
   logic                  verify_mode_in;
   logic                  sel_verify;
   logic                  wr_en;

   // Decode the word index
   assign sel_verify = (csr_paddr[CSR_ADDR_W-1:2] == REG_VERIFY_MODE);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Update the mode on the access phase of a write
   always_comb begin
      verify_mode_in = verify_mode_ff;
      if (wr_en && sel_verify) begin
         verify_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verify_mode_ff <= 1'b0;
      end else begin
         verify_mode_ff <= verify_mode_in;
      end
   end

   // Read back
   assign csr_prdata = sel_verify ? {{(CSR_DATA_W-1){1'b0}}, verify_mode_ff}
                                  : '0;

   assign cfg.verify_mode = verify_mode_ff;

endmodule

### rtl/fcch_core.sv
// ----------------------------------------------------------------------------
// fcch_core: checksum datapath
// Input register, running message state and result register; one character
// is processed per cycle while the result slot is free or being emptied.
// ----------------------------------------------------------------------------
module fcch_core
   import fcch_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   fcch_req_if.sink   req_chan,
   fcch_rsp_if.source rsp_chan
);

   // Input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // Message state
   logic [SUM_W-1:0]  sum_ff,  sum_in;
   logic [CHAR_W-1:0] prev_ff, prev_in;
   logic [CHAR_W-1:0] prev2_ff, prev2_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_hex_high_ff, out_hex_low_ff;
   logic              out_ok_ff;

   // Datapath terms
   logic              advance;
   logic              take_req;
   logic              fire;
   logic              char_ok;
   logic [SUM_W-1:0]  sum_nx;
   logic [CHAR_W-1:0] prev_nx, prev2_nx;
   logic [CNT_W-1:0]  cnt_nx;
   logic [SUM_W-1:0]  pair_sum;
   logic [SUM_W-1:0]  stripped;
   logic [CHAR_W-1:0] hi_val, lo_val, rx_byte, total, ck;
   logic [CHAR_W-1:0] hex_high_nx, hex_low_nx;
   logic              ok_nx;

   // Pipeline moves when the result slot is free or being emptied
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take_req       = req_chan.valid && req_chan.ready;
   assign fire           = in_valid_ff && advance;

   // Accumulate valid characters and track the trailing pair
   always_comb begin
      char_ok  = char_counts(in_char_ff);
      sum_nx   = char_ok ? sum_ff + {{(SUM_W-CHAR_W){1'b0}}, in_char_ff} : sum_ff;
      prev_nx  = char_ok ? in_char_ff : prev_ff;
      prev2_nx = char_ok ? prev_ff : prev2_ff;
      cnt_nx   = (char_ok && (cnt_ff != CNT_FULL)) ? cnt_ff + 2'd1 : cnt_ff;
   end

   // Generate: complement of the fold as hex. Verify: strip pair, add its value.
   always_comb begin
      ck          = ~fold_sum(sum_nx);
      pair_sum    = {{(SUM_W-CHAR_W){1'b0}}, prev2_nx} + {{(SUM_W-CHAR_W){1'b0}}, prev_nx};
      stripped    = sum_nx - pair_sum;
      hi_val      = ascii_to_value(prev2_nx);
      lo_val      = ascii_to_value(prev_nx);
      rx_byte     = {hi_val[3:0], 4'b0} | lo_val;
      total       = fold_sum(stripped) + rx_byte;
      hex_high_nx = cfg.verify_mode ? '0 : nibble_to_ascii(ck[7:4]);
      hex_low_nx  = cfg.verify_mode ? '0 : nibble_to_ascii(ck[3:0]);
      ok_nx       = cfg.verify_mode && (cnt_nx == CNT_FULL) && (total == CHECK_GOOD);
   end

   // Next state of the control and message registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      cnt_in       = cnt_ff;
      if (advance) begin
         out_valid_in = fire && in_last_ff;
         in_valid_in  = 1'b0;
      end
      if (take_req) begin
         in_valid_in = 1'b1;
      end
      if (fire) begin
         if (in_last_ff) begin
            sum_in   = '0;
            prev_in  = '0;
            prev2_in = '0;
            cnt_in   = '0;
         end else begin
            sum_in   = sum_nx;
            prev_in  = prev_nx;
            prev2_in = prev2_nx;
            cnt_in   = cnt_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         prev2_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_chan.char_in;
         in_last_ff <= req_chan.last_char;
      end
      if (fire && in_last_ff) begin
         out_hex_high_ff <= hex_high_nx;
         out_hex_low_ff  <= hex_low_nx;
         out_ok_ff       <= ok_nx;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.hex_high = out_hex_high_ff;
   assign rsp_chan.hex_low  = out_hex_low_ff;
   assign rsp_chan.check_ok = out_ok_ff;

`ifndef SYNTH
   // A last character leaves the message state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |=> (sum_ff == '0 && cnt_ff == '0 &&
                                prev_ff == '0 && prev2_ff == '0))
      else $error("message state not cleared after last character");

   // The valid-character count saturates at two
   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("valid character count overran");

   // A new result only follows a processed last character
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_last_ff && advance))
      else $error("result raised without a last character");

   // A passing check carries no hex characters
   a_ok_no_hex: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ok_ff) |-> (out_hex_high_ff == '0 && out_hex_low_ff == '0))
      else $error("verify result carries hex characters");
`endif

endmodule

### rtl/filtered_char_checksum_hex.sv
// ----------------------------------------------------------------------------
// filtered_char_checksum_hex: filtered 8-bit character checksum
// Generates or verifies a two-character hex checksum over a character stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one character per transaction with last_char marking the
//   end of a message. Only digits, capital letters and space count towards
//   the 16-bit running sum; other characters are skipped but still end a
//   message when marked last.
//   rsp_chan carries one result per message, after its last character. In
//   generate mode hex_high/hex_low hold the complemented folded sum as ASCII
//   hex and check_ok is 0; in verify mode the trailing two counted characters
//   are read as the checksum and check_ok reports the match, hex fields 0.
//   The csr port selects the mode (register 0, bit 0); write it only while no
//   message is in flight.
// Timing:
//   One transaction per cycle is accepted unless a waiting result stalls the
//   block. A last character is first captured in the input register, then
//   the checksum logic loads the result register that drives rsp_chan.
// Reset and stall:
//   Reset clears the mode to generate and the running message state. While a
//   result waits on rsp_chan the input register holds, so req_chan stalls
//   after at most one further transaction.
// ----------------------------------------------------------------------------
module filtered_char_checksum_hex
   import fcch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fcch_req_if.sink              req_chan,
   fcch_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Configuration registers
   fcch_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Checksum datapath
   fcch_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### sim/filtered_char_checksum_hex_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filtered_char_checksum_hex_test: checksum generate/verify regression
// Streams character messages into the block in both modes. A local model
// tracks the filtered running sum and predicts every result, which is
// compared field by field against the result channel. Sender gaps and
// receiver stalls vary by phase, and the mode register is exercised between
// phases.
// ----------------------------------------------------------------------------
module filtered_char_checksum_hex_test;
   import fcch_pkg::*;

   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_VERIFY   = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] VERIFY_MODE_ADDR = {REG_VERIFY_MODE, 2'b00};
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 50;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_beat_type;

   typedef struct packed {
      logic [CHAR_W-1:0] hex_high;
      logic [CHAR_W-1:0] hex_low;
      logic              check_ok;
   } checksum_type;

   typedef logic [CHAR_W-1:0] char_list_type[$];

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fcch_req_if req_if ();
   fcch_rsp_if rsp_if ();

   filtered_char_checksum_hex uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   char_beat_type char_backlog[$];
   checksum_type  checksum_due[$];
   char_beat_type next_beat;
   checksum_type  due;
   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   int            error_count   = 0;
   int            cycle_count   = 0;

   // Model state: mode shadow and the message accumulator
   logic              mode_shadow   = MODE_GENERATE;
   logic [SUM_W-1:0]  msg_sum       = '0;
   logic [CHAR_W-1:0] newest_char   = '0;
   logic [CHAR_W-1:0] older_char    = '0;
   logic [1:0]        counted_chars = '0;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Checksum arithmetic
   // ---------------------------------------------------------------------
   function automatic logic counts(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h20;
   endfunction

   function automatic logic [CHAR_W-1:0] fold8(input logic [SUM_W-1:0] s);
      logic [CHAR_W-1:0] f;
      f = s[7:0] + s[15:8];
      return f;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
      logic [CHAR_W-1:0] w;
      w = {4'h0, n};
      return (n > 4'd9) ? w + 8'd55 : w + 8'd48;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] v;
      v = (c >= 8'h41 && c <= 8'h5A) ? c - 8'd55 : c - 8'd48;
      return v;
   endfunction

   // Accumulate one accepted character; on the last one queue the result
   function automatic void absorb_char(input logic [CHAR_W-1:0] c, input logic last);
      checksum_type      res;
      logic [CHAR_W-1:0] ck;
      logic [SUM_W-1:0]  trimmed;
      logic [CHAR_W-1:0] high_val;
      logic [CHAR_W-1:0] pair_byte;
      logic [CHAR_W-1:0] total;
      if (counts(c)) begin
         msg_sum     = msg_sum + {8'h00, c};
         older_char  = newest_char;
         newest_char = c;
         if (counted_chars < 2'd2) counted_chars = counted_chars + 2'd1;
      end
      if (!last) return;
      res = '0;
      if (mode_shadow == MODE_GENERATE) begin
         ck = ~fold8(msg_sum);
         res.hex_high = hex_char(ck[7:4]);
         res.hex_low  = hex_char(ck[3:0]);
      end else if (counted_chars == 2'd2) begin
         trimmed   = msg_sum - ({8'h00, older_char} + {8'h00, newest_char});
         high_val  = hex_value(older_char);
         pair_byte = {high_val[3:0], 4'h0} | hex_value(newest_char);
         total     = fold8(trimmed) + pair_byte;
         res.check_ok = (total == 8'hFF);
      end
      checksum_due.push_back(res);
      msg_sum       = '0;
      newest_char   = '0;
      older_char    = '0;
      counted_chars = '0;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   function automatic void queue_char(input logic [CHAR_W-1:0] c, input logic last);
      char_backlog.push_back('{ch: c, last: last});
   endfunction

   // Mostly counted characters, the rest any byte
   function automatic logic [CHAR_W-1:0] random_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return CHAR_W'($urandom_range(255));
      else if (r < 60) return 8'h30 + CHAR_W'($urandom_range(9));
      else if (r < 90) return 8'h41 + CHAR_W'($urandom_range(25));
      return 8'h20;
   endfunction

   function automatic logic [CHAR_W-1:0] noise_char();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(255)); while (counts(c));
      return c;
   endfunction

   function automatic int queue_plain_message(input int max_len);
      int len;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) queue_char(random_char(), i == len - 1);
      return len;
   endfunction

   // Body, then the hex checksum pair (optionally spoilt), then noise
   function automatic int queue_signed_message(input char_list_type body, input logic spoil,
                                               input int tail);
      logic [SUM_W-1:0]  sum;
      logic [CHAR_W-1:0] ck;
      logic [CHAR_W-1:0] hi;
      logic [CHAR_W-1:0] lo;
      sum = '0;
      foreach (body[i]) begin
         queue_char(body[i], 1'b0);
         if (counts(body[i])) sum = sum + {8'h00, body[i]};
      end
      ck = ~fold8(sum);
      hi = hex_char(ck[7:4]);
      lo = hex_char(ck[3:0]);
      if (spoil) begin
         if ($urandom_range(1)) hi = 8'h41 + CHAR_W'($urandom_range(25));
         else lo = 8'h30 + CHAR_W'($urandom_range(9));
      end
      queue_char(hi, 1'b0);
      queue_char(lo, tail == 0);
      for (int t = 0; t < tail; t++) queue_char(noise_char(), t == tail - 1);
      return body.size() + 2 + tail;
   endfunction

   // ---------------------------------------------------------------------
   // Character driver: feed the block from the backlog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) absorb_char(req_if.char_in, req_if.last_char);
         if (!req_if.valid || req_if.ready) begin
            if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = char_backlog.pop_front();
               req_if.valid     <= 1'b1;
               req_if.char_in   <= next_beat.ch;
               req_if.last_char <= next_beat.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: stall at random, check each transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (checksum_due.size() == 0) begin
               $display("%0t: unexpected result hex_high %h hex_low %h check_ok %b", $time,
                        rsp_if.hex_high, rsp_if.hex_low, rsp_if.check_ok);
               error_count++;
            end else begin
               due = checksum_due.pop_front();
               if (rsp_if.hex_high !== due.hex_high) begin
                  $display("%0t: hex_high expected %h, got %h", $time, due.hex_high,
                           rsp_if.hex_high);
                  error_count++;
               end
               if (rsp_if.hex_low !== due.hex_low) begin
                  $display("%0t: hex_low expected %h, got %h", $time, due.hex_low,
                           rsp_if.hex_low);
                  error_count++;
               end
               if (rsp_if.check_ok !== due.check_ok) begin
                  $display("%0t: check_ok expected %b, got %b", $time, due.check_ok,
                           rsp_if.check_ok);
                  error_count++;
               end
            end
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("filtered_char_checksum_hex regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Register access
   // ---------------------------------------------------------------------
   task automatic csr_write_mode(input logic mode);
      logic [CSR_DATA_W-1:0] wdata;
      wdata    = $urandom();
      wdata[0] = mode;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= VERIFY_MODE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mode_shadow = mode;
      @(negedge clock);
   endtask

   task automatic csr_check_mode();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= VERIFY_MODE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(CSR_DATA_W-1){1'b0}}, mode_shadow}) begin
         $display("%0t: verify_mode read expected %h, got %h", $time,
                  {{(CSR_DATA_W-1){1'b0}}, mode_shadow}, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every character is taken and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (char_backlog.size() != 0 || req_if.valid || checksum_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      char_list_type body;
      int            items;
      int            r;
      int            idle_set[4][2];

      idle_set = '{'{0, 0}, '{64, 0}, '{0, 64}, '{31, 31}};
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_in   = '0;
      req_if.last_char = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Mode after reset is generate
      csr_check_mode();

      // Generate mode: extremes, class boundaries, fold with a high byte
      queue_char("0", 1'b1);
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b1);
      queue_char("9", 1'b0);
      queue_char("A", 1'b0);
      queue_char("Z", 1'b0);
      queue_char(" ", 1'b0);
      queue_char(8'h2F, 1'b0);
      queue_char(8'h3A, 1'b0);
      queue_char(8'h40, 1'b0);
      queue_char(8'h5B, 1'b1);
      queue_char("Z", 1'b0);
      queue_char("Z", 1'b0);
      queue_char("Z", 1'b1);
      // Longer message so the fold carries a large high byte
      for (int i = 0; i < 60; i++) queue_char("Z", i == 59);
      drain();

      // Verify mode: short messages, exact pair, good and spoilt checksums
      csr_write_mode(MODE_VERIFY);
      csr_check_mode();
      queue_char("5", 1'b1);
      queue_char(8'h7F, 1'b1);
      queue_char("F", 1'b0);
      queue_char("F", 1'b1);
      body = '{"A", "B", "C"};
      void'(queue_signed_message(body, 1'b0, 0));
      queue_char("Z", 1'b0);
      queue_char(" ", 1'b1);
      body = '{"H", 8'h2E, "I"};
      void'(queue_signed_message(body, 1'b0, 1));
      body.delete();
      void'(queue_signed_message(body, 1'b1, 0));
      drain();

      // Random phases under each idling pattern, both modes in each
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p][0];
         stall_pct     = idle_set[p][1];

         csr_write_mode(MODE_GENERATE);
         csr_check_mode();
         items = 0;
         while (items < PHASE_ITEMS) items += queue_plain_message(12);
         drain();

         csr_write_mode(MODE_VERIFY);
         csr_check_mode();
         items = 0;
         while (items < PHASE_ITEMS) begin
            r = $urandom_range(99);
            body.delete();
            repeat ($urandom_range(0, 10)) body.push_back(random_char());
            if (r < 70)
               items += queue_signed_message(body, 1'b0,
                                             ($urandom_range(3) == 0) ? $urandom_range(1, 2)
                                                                      : 0);
            else if (r < 85)
               items += queue_signed_message(body, 1'b1, 0);
            else
               items += queue_plain_message(4);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("filtered_char_checksum_hex regression: pass");
      end else begin
         $display("filtered_char_checksum_hex regression: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/fcch_pkg.sv
rtl/fcch_req_if.sv
rtl/fcch_rsp_if.sv
rtl/fcch_csr.sv
rtl/fcch_core.sv
rtl/filtered_char_checksum_hex.sv
sim/filtered_char_checksum_hex_test.sv
